// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CHK_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

// expression must never hold
`define CHK_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("check failed: forbidden condition");

`endif

// ----- sv/mcod_pkg.sv -----
// ---------------------------------------------------------------------------
// mcod_pkg
// Types, widths, opcodes and a saturating adder for the matrix chain core.
// ---------------------------------------------------------------------------
package mcod_pkg;

    localparam int MAX_MATRICES_DEF = 32;
    localparam int DIM_BITS         = 12;
    localparam int COST_BITS        = 48;
    localparam int SPLIT_BITS       = 6;
    localparam int QIDX_BITS        = 6;
    localparam int PROD_BITS        = 3 * DIM_BITS;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                  opcode;
        logic [DIM_BITS-1:0]   dim_value;
        logic                  last_dim;
        logic [QIDX_BITS-1:0]  query_first;
        logic [QIDX_BITS-1:0]  query_last;
    } cmd_t;

    typedef struct packed {
        logic [COST_BITS-1:0]  min_cost;
        logic [SPLIT_BITS-1:0] split_point;
        logic                  error_flag;
    } res_t;

    // one split candidate issued to the arithmetic unit
    typedef struct packed {
        logic                  valid;
        logic                  first;
        logic                  last;
        logic [SPLIT_BITS-1:0] split;
    } step_ctl_t;

    // best split of an interval, flagged once its last candidate is in
    typedef struct packed {
        logic                  done;
        logic [COST_BITS-1:0]  cost;
        logic [SPLIT_BITS-1:0] split;
    } unit_res_t;

    function automatic logic [COST_BITS-1:0] sat_add(
        input logic [COST_BITS-1:0] a,
        input logic [COST_BITS-1:0] b
    );
        logic [COST_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_BITS] ? {COST_BITS{1'b1}} : s[COST_BITS-1:0];
    endfunction

endpackage

// ----- sv/mcod_ram.sv -----
// ---------------------------------------------------------------------------
// mcod_ram
// Generic RAM: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module mcod_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- sv/mcod_unit.sv -----
// ---------------------------------------------------------------------------
// mcod_unit
// Shared multiply-add-compare pipeline: one split candidate per cycle,
// running minimum with first-wins tie break.
// ---------------------------------------------------------------------------
module mcod_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mcod_pkg::step_ctl_t            step,
    input  logic [mcod_pkg::DIM_BITS-1:0]  di,
    input  logic [mcod_pkg::DIM_BITS-1:0]  dj,
    input  logic [mcod_pkg::DIM_BITS-1:0]  dk,
    input  logic [mcod_pkg::COST_BITS-1:0] cost_a,
    input  logic [mcod_pkg::COST_BITS-1:0] cost_b,
    output mcod_pkg::unit_res_t            result
);

    localparam int DW  = mcod_pkg::DIM_BITS;
    localparam int CW  = mcod_pkg::COST_BITS;
    localparam int P1W = 2 * DW;
    localparam int PW  = mcod_pkg::PROD_BITS;
    localparam int EW  = (PW > CW) ? PW : CW;

    mcod_pkg::step_ctl_t ctl1_reg, ctl2_reg, ctl3_reg;

    logic [CW-1:0]  sum2_reg, sum2_next, sum3_reg;
    logic [P1W-1:0] prod1_reg, prod1_next;
    logic [CW-1:0]  prod3_reg, prod3_next;
    logic [CW-1:0]  best_cost_reg, best_cost_next;
    logic [mcod_pkg::SPLIT_BITS-1:0] best_split_reg, best_split_next;
    logic           done_reg, done_next;

    logic [CW-1:0]  ca, cb, q;
    logic [PW-1:0]  prod_full;
    logic [EW-1:0]  prod_ext;
    logic           take;

    // stage 1: RAM data lands; diagonal terms read as zero
    always_comb
    begin
        ca         = ctl1_reg.first ? '0 : cost_a;
        cb         = ctl1_reg.last  ? '0 : cost_b;
        sum2_next  = mcod_pkg::sat_add(ca, cb);
        prod1_next = P1W'(di) * P1W'(dk);
    end

    // stage 2: second multiply, clamp to cost range
    always_comb
    begin
        prod_full  = PW'(prod1_reg) * PW'(dj);
        prod_ext   = EW'(prod_full);
        prod3_next = (prod_ext > EW'({CW{1'b1}})) ? {CW{1'b1}} : prod_ext[CW-1:0];
    end

    // stage 3: total and running minimum
    always_comb
    begin
        q               = mcod_pkg::sat_add(sum3_reg, prod3_reg);
        take            = ctl3_reg.first || (q < best_cost_reg);
        best_cost_next  = best_cost_reg;
        best_split_next = best_split_reg;
        if (ctl3_reg.valid && take)
        begin
            best_cost_next  = q;
            best_split_next = ctl3_reg.split;
        end
        done_next = ctl3_reg.valid && ctl3_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl1_reg <= step;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum2_reg       <= sum2_next;
        prod1_reg      <= prod1_next;
        sum3_reg       <= sum2_reg;
        prod3_reg      <= prod3_next;
        best_cost_reg  <= best_cost_next;
        best_split_reg <= best_split_next;
    end

    assign result.done  = done_reg;
    assign result.cost  = best_cost_reg;
    assign result.split = best_split_reg;

endmodule

// ----- sv/matrix_chain_order_dp_core.sv -----
// ---------------------------------------------------------------------------
// matrix_chain_order_dp_core
// Matrix chain ordering by interval dynamic programming, one shared
// multiply-add-compare unit under a small sequencer.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  cmd     | in        | cmd_valid / cmd_ready | opcode, dim_value, last_dim,
//          |           |                       | query_first, query_last
//  res     | out       | res_valid / res_ready | min_cost, split_point,
//          |           |                       | error_flag
//
//  Solving: a last load of an n-matrix chain solves every interval in
//  turn, paced by the one-candidate-per-cycle arithmetic unit and its
//  4-deep drain.
//  Reset: asynchronous, clears sequencer, counts and the computed flag;
//  no clearing pass, the RAMs hold nothing meaningful until written.
//  Stalls: cmd_ready is low while a chain is being solved, a query reads
//  the table or a result waits in the output register.
// ---------------------------------------------------------------------------
module matrix_chain_order_dp_core #(
    parameter int MAX_MATRICES = mcod_pkg::MAX_MATRICES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  mcod_pkg::cmd_t cmd,
    output logic           res_valid,
    input  logic           res_ready,
    output mcod_pkg::res_t res
);

    localparam int NDIMS = MAX_MATRICES + 1;
    localparam int MW    = $clog2(MAX_MATRICES);       // zero-based matrix index
    localparam int LW    = $clog2(MAX_MATRICES + 1);   // chain length
    localparam int DA    = $clog2(NDIMS);              // dimension store address
    localparam int CNTW  = $clog2(NDIMS + 1);          // dimension count
    localparam int QW    = (LW > mcod_pkg::QIDX_BITS) ? LW : mcod_pkg::QIDX_BITS;
    localparam int DW    = mcod_pkg::DIM_BITS;
    localparam int CW    = mcod_pkg::COST_BITS;
    localparam int SW    = mcod_pkg::SPLIT_BITS;
    localparam int TW    = CW + SW;                    // table entry: cost, split
    localparam int TD    = 2 ** (2 * MW);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIMRD = 5'b00010,   // fetch outer dimensions of the interval
        S_STEP  = 5'b00100,   // issue one split candidate per cycle
        S_DRAIN = 5'b01000,   // wait for the unit, then store the interval
        S_QRD   = 5'b10000    // table read for a query
    } state_t;

    state_t state_reg, state_next;

    logic [CNTW-1:0] count_reg, count_next;
    logic [LW-1:0]   n_reg, n_next;
    logic            solved_reg, solved_next;
    logic [MW-1:0]   span_reg, span_next;
    logic [MW-1:0]   i0_reg, i0_next;
    logic [MW-1:0]   j0_reg, j0_next;
    logic [MW-1:0]   k0_reg, k0_next;
    logic [DW-1:0]   di_reg, di_next;
    logic [DW-1:0]   dj_reg, dj_next;
    logic            res_valid_reg, res_valid_next;
    mcod_pkg::res_t  res_reg, res_next;

    logic            accept;
    logic            is_load;
    logic            store_full;
    logic [QW-1:0]   qf, ql, n_ext;
    logic            query_bad;
    logic [MW-1:0]   qf_m1, ql_m1;
    logic [MW-1:0]   last_idx;
    logic            first_k, last_k;

    // dimension store ports
    logic            dim_we;
    logic [DA-1:0]   dim_waddr, dim_raddr_a, dim_raddr_b;
    logic [DW-1:0]   dim_rdata_a, dim_rdata_b;

    // interval table ports
    logic            tab_we;
    logic [2*MW-1:0] tab_waddr, tab_raddr_a, tab_raddr_b;
    logic [TW-1:0]   tab_wdata, tab_rdata_a, tab_rdata_b;

    mcod_pkg::step_ctl_t step;
    mcod_pkg::unit_res_t unit_res;

    assign cmd_ready = (state_reg == S_IDLE) && !res_valid_reg;
    assign accept    = cmd_valid && cmd_ready;
    assign is_load   = (cmd.opcode == mcod_pkg::OP_LOAD);
    assign store_full = (count_reg >= CNTW'(NDIMS));

    // query range checks
    assign qf        = QW'(cmd.query_first);
    assign ql        = QW'(cmd.query_last);
    assign n_ext     = QW'(n_reg);
    assign query_bad = !solved_reg || (qf == '0) || (qf > ql) || (ql > n_ext);
    assign qf_m1     = MW'(cmd.query_first - mcod_pkg::QIDX_BITS'(1));
    assign ql_m1     = MW'(cmd.query_last - mcod_pkg::QIDX_BITS'(1));

    assign last_idx  = MW'(n_reg - LW'(1));
    assign first_k   = (k0_reg == i0_reg);
    assign last_k    = ((k0_reg + MW'(1)) == j0_reg);

    // dimension store: write on load unless full, read outer dims then dims[k]
    assign dim_we      = accept && is_load && !store_full;
    assign dim_waddr   = count_reg[DA-1:0];
    assign dim_raddr_a = DA'(i0_reg);
    assign dim_raddr_b = (state_reg == S_STEP) ? (DA'(k0_reg) + DA'(1))
                                               : (DA'(j0_reg) + DA'(1));

    // interval table: (i,k) and (k+1,j) while stepping, query address on port a otherwise
    assign tab_raddr_a = (state_reg == S_STEP) ? {i0_reg, k0_reg} : {qf_m1, ql_m1};
    assign tab_raddr_b = {k0_reg + MW'(1), j0_reg};
    assign tab_we      = (state_reg == S_DRAIN) && unit_res.done;
    assign tab_waddr   = {i0_reg, j0_reg};
    assign tab_wdata   = {unit_res.cost, unit_res.split};

    assign step.valid = (state_reg == S_STEP);
    assign step.first = first_k;
    assign step.last  = last_k;
    assign step.split = SW'({1'b0, k0_reg} + (MW + 1)'(1));

    mcod_ram #(
        .WIDTH (DW),
        .DEPTH (NDIMS)
    ) u_dim_ram (
        .clk     (clk),
        .we      (dim_we),
        .waddr   (dim_waddr),
        .wdata   (cmd.dim_value),
        .raddr_a (dim_raddr_a),
        .rdata_a (dim_rdata_a),
        .raddr_b (dim_raddr_b),
        .rdata_b (dim_rdata_b)
    );

    mcod_ram #(
        .WIDTH (TW),
        .DEPTH (TD)
    ) u_tab_ram (
        .clk     (clk),
        .we      (tab_we),
        .waddr   (tab_waddr),
        .wdata   (tab_wdata),
        .raddr_a (tab_raddr_a),
        .rdata_a (tab_rdata_a),
        .raddr_b (tab_raddr_b),
        .rdata_b (tab_rdata_b)
    );

    mcod_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .di     (di_reg),
        .dj     (dj_reg),
        .dk     (dim_rdata_b),
        .cost_a (tab_rdata_a[TW-1:SW]),
        .cost_b (tab_rdata_b[TW-1:SW]),
        .result (unit_res)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        solved_next    = solved_reg;
        span_next      = span_reg;
        i0_next        = i0_reg;
        j0_next        = j0_reg;
        k0_next        = k0_reg;
        di_next        = di_reg;
        dj_next        = dj_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (is_load)
                    begin
                        if (store_full)
                        begin
                            // overfull: drop the dimension, abandon on last
                            if (cmd.last_dim)
                            begin
                                count_next = '0;
                            end
                            res_valid_next = 1'b1;
                            res_next       = '{min_cost: '0, split_point: '0,
                                               error_flag: 1'b1};
                        end
                        else if (!cmd.last_dim)
                        begin
                            count_next = count_reg + CNTW'(1);
                        end
                        else if (count_reg == '0)
                        begin
                            // chain of one dimension only
                            count_next     = '0;
                            res_valid_next = 1'b1;
                            res_next       = '{min_cost: '0, split_point: '0,
                                               error_flag: 1'b1};
                        end
                        else
                        begin
                            count_next  = '0;
                            n_next      = LW'(count_reg);
                            solved_next = 1'b1;
                            if (count_reg == CNTW'(1))
                            begin
                                // single matrix: nothing to solve
                                res_valid_next = 1'b1;
                                res_next       = '{min_cost: '0, split_point: '0,
                                                   error_flag: 1'b0};
                            end
                            else
                            begin
                                span_next  = MW'(1);
                                i0_next    = '0;
                                j0_next    = MW'(1);
                                state_next = S_DIMRD;
                            end
                        end
                    end
                    else if (query_bad)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = '{min_cost: '0, split_point: '0,
                                           error_flag: 1'b1};
                    end
                    else if (qf == ql)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = '{min_cost: '0, split_point: '0,
                                           error_flag: 1'b0};
                    end
                    else
                    begin
                        state_next = S_QRD;
                    end
                end
            end

            S_DIMRD:
            begin
                k0_next    = i0_reg;
                state_next = S_STEP;
            end

            S_STEP:
            begin
                // outer dims arrive during the first candidate cycle
                if (first_k)
                begin
                    di_next = dim_rdata_a;
                    dj_next = dim_rdata_b;
                end
                k0_next = k0_reg + MW'(1);
                if (last_k)
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                if (unit_res.done)
                begin
                    if (j0_reg == last_idx)
                    begin
                        if (i0_reg == '0)
                        begin
                            // whole chain done
                            res_valid_next = 1'b1;
                            res_next       = '{min_cost: unit_res.cost,
                                               split_point: unit_res.split,
                                               error_flag: 1'b0};
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            span_next  = span_reg + MW'(1);
                            i0_next    = '0;
                            j0_next    = span_reg + MW'(1);
                            state_next = S_DIMRD;
                        end
                    end
                    else
                    begin
                        i0_next    = i0_reg + MW'(1);
                        j0_next    = j0_reg + MW'(1);
                        state_next = S_DIMRD;
                    end
                end
            end

            S_QRD:
            begin
                res_valid_next = 1'b1;
                res_next       = '{min_cost: tab_rdata_a[TW-1:SW],
                                   split_point: tab_rdata_a[SW-1:0],
                                   error_flag: 1'b0};
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            n_reg         <= '0;
            solved_reg    <= 1'b0;
            span_reg      <= '0;
            i0_reg        <= '0;
            j0_reg        <= '0;
            k0_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            solved_reg    <= solved_next;
            span_reg      <= span_next;
            i0_reg        <= i0_next;
            j0_reg        <= j0_next;
            k0_reg        <= k0_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        di_reg  <= di_next;
        dj_reg  <= dj_next;
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- sv/mcod_checker.sv -----
// ---------------------------------------------------------------------------
// mcod_checker
// Port-level checks on the matrix chain core, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mcod_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_valid,
    input logic           cmd_ready,
    input mcod_pkg::cmd_t cmd,
    input logic           res_valid,
    input logic           res_ready,
    input mcod_pkg::res_t res
);

    logic query_zero;

    assign query_zero = cmd_valid && cmd_ready && (cmd.opcode == mcod_pkg::OP_QUERY)
                        && (cmd.query_first == '0);

    // a stalled result holds
    `CHK_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))

    // one item at a time: no new transfer while a result waits
    `CHK_NEVER(a_busy_out, cmd_ready && res_valid)

    // an error result carries no cost and no split
    `CHK_NOW(a_err_zero, res_valid && res.error_flag, (res.min_cost == '0) && (res.split_point == '0))

    // a query starting at matrix zero is refused in the next cycle
    `CHK_NEXT(a_query_zero, query_zero, res_valid && res.error_flag)

endmodule

bind matrix_chain_order_dp_core mcod_checker u_mcod_checker (.*);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the matrix chain ordering core. Dimension loads
// and interval queries go in over a valid/ready channel. A bit-accurate
// interval solver in the bench predicts each result, and every result
// transfer is checked field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_top;

    import mcod_pkg::*;

    localparam int          MAXM           = MAX_MATRICES_DEF;
    localparam int          NDIMS          = MAXM + 1;
    localparam int          DIM_MAX        = (1 << DIM_BITS) - 1;
    localparam int          QIDX_MAX       = (1 << QIDX_BITS) - 1;
    localparam logic [63:0] COST_LIMIT     = (64'd1 << COST_BITS) - 64'd1;
    // a full 32-matrix solve runs with no transfer at all
    localparam int          WATCHDOG_LIMIT = 40000;
    localparam int          RANDOM_ITEMS   = 1600;
    localparam int          QUIET_ITEMS    = 150;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic res_valid;
    logic res_ready;
    res_t res;

    matrix_chain_order_dp_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // -----------------------------------------------------------------------
    // Predictor state: the chain being loaded and the solved interval tables
    // -----------------------------------------------------------------------
    logic [DIM_BITS-1:0]   dim_mem   [0:NDIMS-1];
    logic [COST_BITS-1:0]  cost_mem  [1:MAXM][1:MAXM];
    logic [SPLIT_BITS-1:0] split_mem [1:MAXM][1:MAXM];
    int unsigned           dim_cnt;
    int unsigned           chain_len;
    bit                    chain_ready;

    res_t pending_results[$];
    res_t expected_head;

    // run statistics
    int n_loads, n_queries, n_solved;
    int n_checked   = 0;
    int n_error_res = 0;
    int mismatches  = 0;
    int idle_cycles = 0;
    int stall_left;
    bit quiet;       // no idling on either side in the closing part

    // -----------------------------------------------------------------------
    // Clock and reset
    // -----------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Interval solver: cheapest split for every i..j, smallest k on ties
    // because only a strictly smaller cost replaces the current best.
    // Every sum and product saturates at the cost width.
    // -----------------------------------------------------------------------
    function automatic void solve_intervals(input int n);
        logic [63:0] best, cand, prod, da, dk, dj;
        int          j, best_k;
        for (int i = 1; i <= n; i++)
        begin
            cost_mem[i][i]  = '0;
            split_mem[i][i] = '0;
        end
        for (int span = 2; span <= n; span++)
        begin
            for (int i = 1; i + span - 1 <= n; i++)
            begin
                j      = i + span - 1;
                best   = '0;
                best_k = i;
                for (int k = i; k < j; k++)
                begin
                    da   = 64'(dim_mem[i-1]);
                    dk   = 64'(dim_mem[k]);
                    dj   = 64'(dim_mem[j]);
                    prod = da * dk * dj;
                    if (prod > COST_LIMIT)
                        prod = COST_LIMIT;
                    cand = 64'(cost_mem[i][k]);
                    cand = cand + 64'(cost_mem[k+1][j]);
                    if (cand > COST_LIMIT)
                        cand = COST_LIMIT;
                    cand = cand + prod;
                    if (cand > COST_LIMIT)
                        cand = COST_LIMIT;
                    if (k == i || cand < best)
                    begin
                        best   = cand;
                        best_k = k;
                    end
                end
                cost_mem[i][j]  = best[COST_BITS-1:0];
                split_mem[i][j] = best_k[SPLIT_BITS-1:0];
            end
        end
    endfunction

    // Advance the predictor by one accepted command; produces is cleared for
    // a plain load, the only command that gives no result.
    function automatic void predict_cmd(input cmd_t c, output bit produces, output res_t r);
        r        = '0;
        produces = 1'b1;
        if (c.opcode == OP_LOAD)
        begin
            if (dim_cnt >= NDIMS)
            begin
                // store full: dimension dropped, a last load abandons the chain
                if (c.last_dim)
                    dim_cnt = 0;
                r.error_flag = 1'b1;
            end
            else
            begin
                dim_mem[dim_cnt] = c.dim_value;
                dim_cnt++;
                if (!c.last_dim)
                    produces = 1'b0;
                else if (dim_cnt < 2)
                begin
                    // too short: the previous chain stays queryable
                    dim_cnt      = 0;
                    r.error_flag = 1'b1;
                end
                else
                begin
                    chain_len = dim_cnt - 1;
                    solve_intervals(chain_len);
                    chain_ready   = 1'b1;
                    dim_cnt       = 0;
                    n_solved++;
                    r.min_cost    = cost_mem[1][chain_len];
                    r.split_point = split_mem[1][chain_len];
                end
            end
        end
        else if (!chain_ready || c.query_first == 0 || c.query_first > c.query_last ||
                 c.query_last > chain_len)
            r.error_flag = 1'b1;
        else
        begin
            r.min_cost    = cost_mem[c.query_first][c.query_last];
            r.split_point = split_mem[c.query_first][c.query_last];
        end
    endfunction

    // -----------------------------------------------------------------------
    // Command builders: fields a command ignores are filled with noise
    // -----------------------------------------------------------------------
    function automatic cmd_t load_cmd(input int d, input bit last);
        cmd_t c;
        c.opcode      = OP_LOAD;
        c.dim_value   = DIM_BITS'(d);
        c.last_dim    = last;
        c.query_first = QIDX_BITS'($urandom_range(0, QIDX_MAX));
        c.query_last  = QIDX_BITS'($urandom_range(0, QIDX_MAX));
        return c;
    endfunction

    function automatic cmd_t query_cmd(input int qf, input int ql);
        cmd_t c;
        c.opcode      = OP_QUERY;
        c.dim_value   = DIM_BITS'($urandom_range(0, DIM_MAX));
        c.last_dim    = 1'($urandom_range(0, 1));
        c.query_first = QIDX_BITS'(qf);
        c.query_last  = QIDX_BITS'(ql);
        return c;
    endfunction

    // dimension flavours: small values, full range, or biased to the extremes
    function automatic int pick_dim(input int flavour);
        case (flavour)
            0:       return $urandom_range(1, 15);
            1:       return $urandom_range(0, DIM_MAX);
            default:
                case ($urandom_range(0, 3))
                    0:       return 0;
                    1:       return 1;
                    2:       return DIM_MAX;
                    default: return $urandom_range(0, DIM_MAX);
                endcase
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Command side: optional gap, then hold valid until the transfer
    // -----------------------------------------------------------------------
    task automatic send_cmd(input cmd_t c);
        bit   produces;
        res_t predicted;
        if (!quiet && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 17)) @(negedge clk);
        cmd_valid = 1'b1;
        cmd       = c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        // transfer taken at this edge: predict before anything else moves
        predict_cmd(c, produces, predicted);
        if (produces)
            pending_results.push_back(predicted);
        if (c.opcode == OP_LOAD)
            n_loads++;
        else
            n_queries++;
        @(negedge clk);
        cmd_valid = 1'b0;
    endtask

    // mostly well-formed queries of the solved chain, some of anything
    task automatic send_queries(input int count);
        int qf, ql;
        repeat (count)
        begin
            if (chain_ready && $urandom_range(0, 6) != 0)
            begin
                qf = $urandom_range(1, chain_len);
                ql = $urandom_range(qf, chain_len);
            end
            else
            begin
                qf = $urandom_range(0, QIDX_MAX);
                ql = $urandom_range(0, QIDX_MAX);
            end
            send_cmd(query_cmd(qf, ql));
        end
    endtask

    // n_mat matrices need n_mat + 1 dimensions; queries may slip in between
    task automatic send_chain(input int n_mat);
        int flavour;
        flavour = $urandom_range(0, 2);
        for (int d = 0; d <= n_mat; d++)
        begin
            if (d != 0 && $urandom_range(0, 9) == 0)
                send_queries(1);
            send_cmd(load_cmd(pick_dim(flavour), d == n_mat));
        end
    endtask

    // fill the store, maybe push past it, then abandon with a last load
    task automatic send_overfull();
        repeat (NDIMS) send_cmd(load_cmd(pick_dim(1), 1'b0));
        repeat ($urandom_range(0, 2)) send_cmd(load_cmd(pick_dim(1), 1'b0));
        send_cmd(load_cmd(pick_dim(1), 1'b1));
    endtask

    // -----------------------------------------------------------------------
    // Result side: random stall bursts on res_ready
    // -----------------------------------------------------------------------
    initial
    begin
        res_ready  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                res_ready = 1'b0;
                stall_left--;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                res_ready  = 1'b0;
                stall_left = $urandom_range(0, 16);
            end
            else
                res_ready = 1'b1;
        end
    end

    // -----------------------------------------------------------------------
    // Checker: every result transfer against the oldest prediction
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            n_checked++;
            if (res.error_flag)
                n_error_res++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected, actual cost=%0d split=%0d err=%0b",
                         $realtime, res.min_cost, res.split_point, res.error_flag);
                mismatches++;
            end
            else
            begin
                expected_head = pending_results.pop_front();
                if (res.min_cost !== expected_head.min_cost)
                begin
                    $display("%0t: min_cost expected %0d actual %0d", $realtime,
                             expected_head.min_cost, res.min_cost);
                    mismatches++;
                end
                if (res.split_point !== expected_head.split_point)
                begin
                    $display("%0t: split_point expected %0d actual %0d", $realtime,
                             expected_head.split_point, res.split_point);
                    mismatches++;
                end
                if (res.error_flag !== expected_head.error_flag)
                begin
                    $display("%0t: error_flag expected %0b actual %0b", $realtime,
                             expected_head.error_flag, res.error_flag);
                    mismatches++;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog: too long without a transfer on either channel
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, %0d cycles without a transfer, %0d results outstanding",
                     $realtime, idle_cycles, pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // extremes, every command and the query and short-chain error paths
    task automatic test_directed_corners();
        send_cmd(query_cmd(1, 1));              // nothing solved yet
        send_cmd(load_cmd(DIM_MAX, 1'b1));      // lone dimension: chain too short
        send_cmd(load_cmd(DIM_MAX, 1'b0));
        send_cmd(load_cmd(0, 1'b0));
        send_cmd(load_cmd(DIM_MAX, 1'b0));
        send_cmd(load_cmd(DIM_MAX, 1'b1));      // 3 matrices, zero dimension inside
        send_cmd(query_cmd(1, 3));
        send_cmd(query_cmd(2, 3));
        send_cmd(query_cmd(1, 1));
        send_cmd(query_cmd(3, 3));
        send_cmd(query_cmd(0, 2));              // first index zero
        send_cmd(query_cmd(3, 2));              // reversed interval
        send_cmd(query_cmd(1, 4));              // one past the chain
        send_cmd(query_cmd(QIDX_MAX, QIDX_MAX));
        // equal dimensions: every split ties, the first must win
        repeat (3) send_cmd(load_cmd(7, 1'b0));
        send_cmd(load_cmd(7, 1'b1));
        send_cmd(query_cmd(1, 3));
        send_cmd(query_cmd(1, 2));
        // a rejected short chain leaves the tie chain in place
        send_cmd(load_cmd(5, 1'b1));
        send_cmd(query_cmd(1, 3));
    endtask

    // the largest chain, its boundary queries and the full-store errors
    task automatic test_longest_chain();
        send_chain(MAXM);
        send_cmd(query_cmd(MAXM, MAXM));
        send_cmd(query_cmd(1, MAXM));
        send_cmd(query_cmd(1, MAXM + 1));
        send_cmd(query_cmd(QIDX_MAX, 1));
        send_overfull();
        send_queries(3);
    endtask

    // well-formed chains with random content, plus noise and broken chains
    task automatic test_random_mix(input int target);
        int pick;
        while (n_loads + n_queries < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
                send_chain(MAXM);
            else if (pick < 4)
                send_overfull();
            else if (pick < 8)
                send_cmd(load_cmd(pick_dim(2), 1'b1));
            else if (pick < 15)
                repeat ($urandom_range(1, 4))
                    send_cmd(query_cmd($urandom_range(0, QIDX_MAX),
                                       $urandom_range(0, QIDX_MAX)));
            else
                send_chain($urandom_range(1, 8));
            send_queries($urandom_range(1, 6));
        end
    endtask

    // back-to-back transfers with no idling on either side
    task automatic test_back_to_back(input int count);
        int stop_at;
        stop_at = n_loads + n_queries + count;
        quiet   = 1'b1;
        while (n_loads + n_queries < stop_at)
        begin
            send_chain($urandom_range(1, 6));
            send_queries($urandom_range(2, 5));
        end
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        cmd_valid   = 1'b0;
        cmd         = '0;
        quiet       = 1'b0;
        dim_cnt     = 0;
        chain_len   = 0;
        chain_ready = 1'b0;
        n_loads     = 0;
        n_queries   = 0;
        n_solved    = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_corners();
        test_longest_chain();
        test_random_mix(RANDOM_ITEMS);
        test_back_to_back(QUIET_ITEMS);

        // drain, then a short settle so any stray result would still show
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Run covered %0d loads and %0d queries, %0d chains solved",
                 n_loads, n_queries, n_solved);
        $display("%0d results checked, %0d of them error results", n_checked, n_error_res);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/mcod_pkg.sv
sv/mcod_ram.sv
sv/mcod_unit.sv
sv/matrix_chain_order_dp_core.sv
sv/mcod_checker.sv
test/tb_top.sv
